/* src/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key-value cache
// Operation codes, result select codes, reset constants and the tag-side
// response struct passed from the tag array to the top level.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Default number of cache entries
  localparam int DEFAULT_ENTRIES = 16;

  // Capacity register value after reset
  localparam int CAP_RESET = 16;

  // Field widths fixed by the item format
  localparam int FUNC_W  = 1;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_GET = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PUT = 1'b1;

  // Value returned by a get that misses
  localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

  // Source of the read_value field of a result
  typedef enum logic [1:0] {
    RD_ZERO = 2'd0,
    RD_MISS = 2'd1,
    RD_MEM  = 2'd2
  } rd_sel_t;

  // Lookup outcome from the tag array
  typedef struct packed {
    logic    hit;
    logic    wr_value;
    rd_sel_t rd_sel;
  } tag_resp_t;

endpackage

/* src/lkv_value_ram.sv */
// ----------------------------------------------------------------------------
// lkv_value_ram: value storage for the LRU key-value cache
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lkv_value_ram #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES,
  localparam int IDX_W  = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [IDX_W-1:0]           waddr,
  input  logic [lkv_pkg::VALUE_W-1:0] wdata,
  input  logic                       re,
  input  logic [IDX_W-1:0]           raddr,
  output logic [lkv_pkg::VALUE_W-1:0] rdata
);

  logic [lkv_pkg::VALUE_W-1:0] mem [ENTRIES];
  logic [lkv_pkg::VALUE_W-1:0] rdata_r;

  // Write the stored value of a put
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the value of the looked-up entry
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/lkv_tag_array.sv */
// ----------------------------------------------------------------------------
// lkv_tag_array: key CAM and recency ranks for the LRU key-value cache
// Compares the key against all entries at once, picks the hit, free or
// victim slot, and updates valid bits, keys, ranks and the fill count.
// Rank 0 is most recent; valid entries hold ranks 0 .. count-1.
// ----------------------------------------------------------------------------
module lkv_tag_array #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        req_valid,
  input  logic [lkv_pkg::FUNC_W-1:0]  req_func,
  input  logic [lkv_pkg::KEY_W-1:0]   req_key,
  input  logic [CNT_W-1:0]            cap_eff,
  output lkv_pkg::tag_resp_t          resp,
  output logic [IDX_W-1:0]            slot
);

  logic [ENTRIES-1:0]          valid_r;
  logic [ENTRIES-1:0]          valid_nxt;
  logic [lkv_pkg::KEY_W-1:0]   key_r    [ENTRIES];
  logic [IDX_W-1:0]            rank_r   [ENTRIES];
  logic [IDX_W-1:0]            rank_nxt [ENTRIES];
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            count_nxt;

  logic [ENTRIES-1:0]          match;
  logic [ENTRIES-1:0]          free_vec;
  logic [ENTRIES-1:0]          free_first;
  logic [ENTRIES-1:0]          oldest;
  logic [ENTRIES-1:0]          sel;
  logic [IDX_W-1:0]            last_rank;
  logic [IDX_W-1:0]            hit_rank;
  logic [IDX_W-1:0]            old_rank;
  logic                        hit;
  logic                        is_put;
  logic                        room;
  logic                        fill;
  logic                        do_update;
  logic                        wr_key;

  assign is_put    = (req_func == lkv_pkg::FUNC_PUT);
  assign last_rank = IDX_W'(count_r - CNT_W'(1));
  assign room      = (count_r < cap_eff);

  // Compare every entry in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]    = valid_r[i] && (key_r[i] == req_key);
      free_vec[i] = !valid_r[i];
      oldest[i]   = valid_r[i] && (rank_r[i] == last_rank);
    end
  end

  // Keep the lowest free entry only
  assign free_first = free_vec & (~free_vec + ENTRIES'(1));

  assign hit       = |match;
  assign fill      = is_put && !hit && room;
  assign do_update = req_valid && (hit || is_put);
  assign wr_key    = req_valid && is_put && !hit;

  // Pick the slot: hit entry, else free entry, else least recent entry
  always_comb begin
    if (hit) begin
      sel = match;
    end else if (room) begin
      sel = free_first;
    end else begin
      sel = oldest;
    end
  end

  // Encode the one-hot slot and gather the rank of the hit entry
  always_comb begin
    slot     = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        slot = slot | IDX_W'(i);
      end
      if (match[i]) begin
        hit_rank = hit_rank | rank_r[i];
      end
    end
  end

  assign old_rank = hit ? hit_rank : last_rank;

  // Age every younger entry and make the chosen slot most recent
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel[i]) begin
        rank_nxt[i] = '0;
      end else if (valid_r[i] && (fill || (rank_r[i] < old_rank))) begin
        rank_nxt[i] = rank_r[i] + IDX_W'(1);
      end else begin
        rank_nxt[i] = rank_r[i];
      end
    end
    valid_nxt = valid_r | (fill ? free_first : '0);
    count_nxt = fill ? count_r + CNT_W'(1) : count_r;
  end

  // Hold valid bits, ranks and fill count
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (do_update) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // Store the key of a newly placed entry
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_key && sel[i]) begin
        key_r[i] <= req_key;
      end
    end
  end

  // Report the lookup outcome
  always_comb begin
    resp.hit      = hit;
    resp.wr_value = req_valid && is_put;
    if (is_put) begin
      resp.rd_sel = lkv_pkg::RD_ZERO;
    end else if (hit) begin
      resp.rd_sel = lkv_pkg::RD_MEM;
    end else begin
      resp.rd_sel = lkv_pkg::RD_MISS;
    end
  end

endmodule

/* src/lru_key_value_cache.sv */
// An LRU key-value cache that takes one get or put every clock cycle: busy
// stays low, so start may be held high continuously. Each item produces
// exactly one result, registered first in the input register and then in the
// result register and flagged by a one-cycle out_valid pulse; the receiver
// cannot stall, so results must be captured when shown. The result path runs
// through the input register, one pass through the key CAM and rank update,
// and the registered read of the value memory. Writing the capacity clears the
// whole cache; write it only while no item is in flight.
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache with LRU replacement
// Input register, tag array with recency ranks, value memory and result
// register.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic [lkv_pkg::FUNC_W-1:0]   in_func,
  input  logic [lkv_pkg::KEY_W-1:0]    in_key,
  input  logic signed [lkv_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                         out_valid,
  output logic                         out_hit,
  output logic signed [lkv_pkg::VALUE_W-1:0] out_read_value,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]    cfg_capacity_in_use
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
  localparam int CAP_RESET_EFF =
    (lkv_pkg::CAP_RESET > ENTRIES) ? ENTRIES : lkv_pkg::CAP_RESET;

  logic                          in_valid_r;
  logic [lkv_pkg::FUNC_W-1:0]    in_func_r;
  logic [lkv_pkg::KEY_W-1:0]     in_key_r;
  logic [lkv_pkg::VALUE_W-1:0]   in_value_r;

  logic [CNT_W-1:0]              cap_eff_r;
  logic [CNT_W-1:0]              cap_eff_nxt;
  logic [CMP_W-1:0]              cap_ext;

  lkv_pkg::tag_resp_t            resp;
  logic [IDX_W-1:0]              slot;
  logic [lkv_pkg::VALUE_W-1:0]   ram_rdata;

  logic                          out_valid_r;
  logic                          out_hit_r;
  lkv_pkg::rd_sel_t              rd_sel_r;

  logic                          accept;
  logic                          cfg_write;

  // Never stall the command side
  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign cfg_ready = !in_valid_r;
  assign cfg_write = cfg_valid && cfg_ready;

  // Clamp the written capacity to 1 .. ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cfg_capacity_in_use);
    if (cap_ext == '0) begin
      cap_eff_nxt = CNT_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff_nxt = CNT_W'(ENTRIES);
    end else begin
      cap_eff_nxt = CNT_W'(cap_ext);
    end
  end

  // Hold the effective capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_eff_r <= CNT_W'(CAP_RESET_EFF);
    end else if (cfg_write) begin
      cap_eff_r <= cap_eff_nxt;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_func_r  <= in_func;
      in_key_r   <= in_key;
      in_value_r <= in_value;
    end
  end

  lkv_tag_array #(
    .ENTRIES (ENTRIES)
  ) u_tag_array (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_write),
    .req_valid (in_valid_r),
    .req_func  (in_func_r),
    .req_key   (in_key_r),
    .cap_eff   (cap_eff_r),
    .resp      (resp),
    .slot      (slot)
  );

  lkv_value_ram #(
    .ENTRIES (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (resp.wr_value),
    .waddr (slot),
    .wdata (in_value_r),
    .re    (in_valid_r),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  // Advance the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_hit_r <= resp.hit;
      rd_sel_r  <= resp.rd_sel;
    end
  end

  // Select the returned value
  always_comb begin
    case (rd_sel_r)
      lkv_pkg::RD_MEM:  out_read_value = ram_rdata;
      lkv_pkg::RD_MISS: out_read_value = lkv_pkg::MISS_VALUE;
      default:          out_read_value = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule
